[rtl/ilid_pkg.sv]
// Shared constants, request/status codes and cell control type for the indexed list.
package ilid_pkg;

   // List storage size, derived index widths and field widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int TYPE_W   = 3;
   localparam int VAL_W    = 32;
   localparam int STAT_W   = 2;

   // Request codes
   localparam logic [TYPE_W-1:0] REQ_GET  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_HEAD = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_TAIL = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_AT   = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_DEL  = 3'd4;

   // Status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // Broadcast to every cell in the chain
   typedef struct packed {
      logic                    do_insert;
      logic                    do_delete;
      logic [CNT_W-1:0]        pos;
      logic signed [VAL_W-1:0] value;
   } ilid_ctrl_type;

endpackage

[rtl/indexed_list_insert_delete_core.sv]
// Top level of the indexed list: request decode, cell chain, count and result register.
// Positional list of up to ilid_pkg::CAPACITY signed 32-bit values held in a row of cells.
// One request beat is taken per clock: an insert or delete shifts every later cell by one
// place in the same cycle, and get reads the addressed cell through a mux. The result beat
// is registered and appears in the cycle after acceptance; a new request is taken whenever
// the result register is empty or its beat is being taken, so throughput is one per cycle.
// Entries start undefined after reset; only the count and the result valid are cleared.
module indexed_list_insert_delete_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ilid_pkg::TYPE_W-1:0]        req_type,
   input  logic [ilid_pkg::CNT_W-1:0]         req_position,
   input  logic signed [ilid_pkg::VAL_W-1:0]  req_new_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ilid_pkg::VAL_W-1:0]  rsp_read_value,
   output logic [ilid_pkg::STAT_W-1:0]        rsp_status,
   output logic [ilid_pkg::CNT_W-1:0]         rsp_entry_count
);

   logic                              accept;
   logic [ilid_pkg::CNT_W-1:0]        count_ff;
   logic [ilid_pkg::CNT_W-1:0]        count_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [ilid_pkg::VAL_W-1:0] rd_value_ff;
   logic signed [ilid_pkg::VAL_W-1:0] rd_value_in;
   logic [ilid_pkg::STAT_W-1:0]       status_ff;
   logic [ilid_pkg::STAT_W-1:0]       status_in;
   logic [ilid_pkg::CNT_W-1:0]        rsp_count_ff;
   logic [ilid_pkg::CNT_W-1:0]        ins_pos;
   logic                              is_insert;
   ilid_pkg::ilid_ctrl_type           ctrl;
   logic signed [ilid_pkg::VAL_W-1:0] cell_value [ilid_pkg::CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Decode: insert slot, range and full checks
   always_comb begin
      is_insert = (req_type == ilid_pkg::REQ_HEAD) || (req_type == ilid_pkg::REQ_TAIL) ||
                  (req_type == ilid_pkg::REQ_AT);
      case (req_type)
         ilid_pkg::REQ_HEAD: ins_pos = '0;
         ilid_pkg::REQ_TAIL: ins_pos = count_ff;
         default:            ins_pos = req_position;
      endcase

      ctrl.do_insert = 1'b0;
      ctrl.do_delete = 1'b0;
      ctrl.pos       = req_position;
      ctrl.value     = req_new_value;
      count_in       = count_ff;
      rd_value_in    = '0;
      status_in      = ilid_pkg::ST_DONE;

      if (is_insert) begin
         ctrl.pos = ins_pos;
         if (ins_pos > count_ff) begin
            status_in = ilid_pkg::ST_RANGE;
         end else if (count_ff == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY)) begin
            status_in = ilid_pkg::ST_FULL;
         end else begin
            ctrl.do_insert = accept;
            count_in       = count_ff + 1'b1;
         end
      end else if (req_type == ilid_pkg::REQ_DEL) begin
         if (req_position < count_ff) begin
            ctrl.do_delete = accept;
            count_in       = count_ff - 1'b1;
         end else begin
            status_in = ilid_pkg::ST_RANGE;
         end
      end else if (req_type == ilid_pkg::REQ_GET) begin
         if (req_position < count_ff) begin
            rd_value_in = cell_value[req_position[ilid_pkg::IDX_W-1:0]];
         end else begin
            rd_value_in = -1;
            status_in   = ilid_pkg::ST_RANGE;
         end
      end
   end

   // Chain of cells, each linked to its neighbours
   for (genvar gi = 0; gi < ilid_pkg::CAPACITY; gi++) begin : g_cell
      logic signed [ilid_pkg::VAL_W-1:0] lower;
      logic signed [ilid_pkg::VAL_W-1:0] upper;
      if (gi == 0) begin : g_first
         assign lower = req_new_value;
      end else begin : g_mid_lo
         assign lower = cell_value[gi-1];
      end
      if (gi == ilid_pkg::CAPACITY - 1) begin : g_last
         assign upper = cell_value[gi];
      end else begin : g_mid_hi
         assign upper = cell_value[gi+1];
      end
      ilid_cell u_cell (
         .clock       (clock),
         .cell_index  (ilid_pkg::IDX_W'(gi)),
         .ctrl        (ctrl),
         .lower_value (lower),
         .upper_value (upper),
         .entry_value (cell_value[gi])
      );
   end

   // Result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_value_ff  <= rd_value_in;
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rd_value_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("count moved without a request beat");

   a_full_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ilid_pkg::ST_FULL |->
      rsp_entry_count == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY))
      else $error("full status with list not full");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_entry_count == count_ff)
      else $error("result count differs from held count");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.do_insert && ctrl.do_delete))
      else $error("insert and delete together");
`endif

endmodule

[rtl/ilid_cell.sv]
// One storage cell of the list chain: holds, takes from a neighbour or loads a new value.
module ilid_cell (
   input  logic                              clock,
   input  logic [ilid_pkg::IDX_W-1:0]        cell_index,
   input  ilid_pkg::ilid_ctrl_type           ctrl,
   input  logic signed [ilid_pkg::VAL_W-1:0] lower_value,
   input  logic signed [ilid_pkg::VAL_W-1:0] upper_value,
   output logic signed [ilid_pkg::VAL_W-1:0] entry_value
);

   logic signed [ilid_pkg::VAL_W-1:0] entry_ff;
   logic signed [ilid_pkg::VAL_W-1:0] entry_in;
   logic [ilid_pkg::CNT_W-1:0]        my_pos;

   assign my_pos = ilid_pkg::CNT_W'(cell_index);

   // insert: cells above the slot take from below, the slot loads the beat value
   // delete: the slot and cells above it take from above
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_insert) begin
         if (my_pos > ctrl.pos) begin
            entry_in = lower_value;
         end else if (my_pos == ctrl.pos) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.do_delete) begin
         if (my_pos >= ctrl.pos) begin
            entry_in = upper_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;

endmodule
